// ===== src/sliding_window_quantile_core_defines.svh =====
// assertion macros shared by the sliding window quantile rtl
`ifndef SLIDING_WINDOW_QUANTILE_CORE_DEFINES_SVH
`define SLIDING_WINDOW_QUANTILE_CORE_DEFINES_SVH
// assert that a implies b on the next cycle, outside reset
`define SWQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
// assert that a implies b in the same cycle, outside reset
`define SWQ_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`endif

// ===== src/swq_pkg.sv =====
// shared types and constants of the sliding window quantile core
package swq_pkg;
    localparam int unsigned SampleW = 16;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned CfgW    = 8;
    localparam logic [TimeW-1:0] StepAdv  = 32'd10;
    localparam logic [TimeW-1:0] DropOffs = 32'd11;
    localparam logic [0:0] RegWindowLen = 1'b0;
    localparam logic [0:0] RegRank      = 1'b1;
    typedef logic signed [SampleW-1:0] t_sample;
    typedef struct packed {
        logic    shift;
        logic    rotate;
    } t_cell_ctl;
endpackage

// ===== src/swq_cell.sv =====
// one history cell: holds a sample, shifts on insert, rotates for the scan
module swq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swq_pkg::t_cell_ctl i_ctl,
    input  swq_pkg::t_sample   i_prev,
    input  swq_pkg::t_sample   i_wrap,
    input  logic               i_last_in_win,
    output swq_pkg::t_sample   o_value
);
    import swq_pkg::*;
    t_sample r_value;
    t_sample n_value;
    always_comb begin
        n_value = r_value;
        if (i_ctl.shift) begin
            n_value = i_prev;
        end else if (i_ctl.rotate) begin
            n_value = i_last_in_win ? i_wrap : i_prev;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end
    assign o_value = r_value;
endmodule

// ===== src/swq_rank_cell.sv =====
// counting cell: compares its held sample with every sample passing the head
module swq_rank_cell #(
    parameter int unsigned CntW = 8
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_count,
    input  swq_pkg::t_sample i_cand,
    input  swq_pkg::t_sample i_probe,
    output swq_pkg::t_sample o_cand,
    output logic [CntW-1:0]  o_below,
    output logic [CntW-1:0]  o_same
);
    import swq_pkg::*;
    t_sample         r_cand;
    logic [CntW-1:0] r_below;
    logic [CntW-1:0] r_same;
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cand  <= i_cand;
            r_below <= '0;
            r_same  <= '0;
        end else if (i_count) begin
            if (i_probe < r_cand) begin
                r_below <= r_below + 1'b1;
            end else if (i_probe == r_cand) begin
                r_same <= r_same + 1'b1;
            end
        end
    end
    assign o_cand  = r_cand;
    assign o_below = r_below;
    assign o_same  = r_same;
endmodule

// ===== src/sliding_window_quantile_core.sv =====
// top level of the sliding window quantile core
//  channel | direction | handshake          | payload
//  in      | in        | i_valid / o_ready  | i_sample_value, i_sample_time
//  out     | out       | o_valid / i_ready  | o_quantile_value
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
// for each item, with n the effective window length,
// the window rotates once per candidate through the head of the cell row,
// so a single rank counter scans all n samples for each of n candidates
// a dropped item emits nothing
// reset is synchronous and clears the history to zero, no clearing pass
// the result waits in an output register; the next item is taken once it leaves
// a pending configuration transaction holds off the input
module sliding_window_quantile_core #(
    parameter int unsigned HISTORY_DEPTH = 150
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [15:0]        i_sample_value,
    input  logic [31:0]               i_sample_time,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [15:0]        o_quantile_value,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [7:0]                i_cfg_data
);
    import swq_pkg::*;
    `include "sliding_window_quantile_core_defines.svh"

    localparam int unsigned IdxW  = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned WideW = CfgW + IdxW;
    localparam logic [WideW-1:0] MaxWin = WideW'(HISTORY_DEPTH - 1);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StLoad = 2'd1;
    localparam logic [1:0] StScan = 2'd2;
    localparam logic [1:0] StDone = 2'd3;

    logic [1:0]        r_state;
    logic [TimeW-1:0]  r_last;
    logic [CfgW-1:0]   r_win_cfg;
    logic [CfgW-1:0]   r_rank_cfg;
    logic [IdxW-1:0]   r_n;       // effective window length
    logic [IdxW-1:0]   r_r;       // effective rank
    logic [IdxW-1:0]   r_cand;    // candidate number
    logic [IdxW-1:0]   r_step;    // rotation step within one pass
    logic              r_found;
    t_sample           r_hit;
    logic              r_out_valid;
    t_sample           r_out;

    t_sample   w_val [HISTORY_DEPTH];
    t_cell_ctl w_ctl;
    t_sample   w_cand;
    logic [IdxW-1:0] w_below;
    logic [IdxW-1:0] w_same;
    logic [IdxW-1:0] w_n;
    logic [IdxW-1:0] w_r;
    logic [WideW-1:0] w_win_wide;
    logic [WideW-1:0] w_rank_wide;
    logic [TimeW:0]  w_lim;
    logic            w_in_acc;
    logic            w_drop;
    logic            w_last_step;

    assign o_ready     = (r_state == StIdle) && !(r_out_valid && !i_ready) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == StIdle) && !r_out_valid;
    assign w_in_acc    = i_valid && o_ready;
    assign w_lim       = {1'b0, r_last} + {1'b0, DropOffs};
    assign w_drop      = ({1'b0, i_sample_time} == w_lim);
    assign w_last_step = (r_step == r_n - 1'b1);

    // effective window and rank from the registers
    always_comb begin
        w_win_wide = (r_win_cfg == '0) ? WideW'(1) : WideW'(r_win_cfg);
        if (w_win_wide > MaxWin) begin
            w_win_wide = MaxWin;
        end
        w_rank_wide = WideW'(r_rank_cfg);
        if (w_rank_wide > w_win_wide - 1'b1) begin
            w_rank_wide = w_win_wide - 1'b1;
        end
        w_n = w_win_wide[IdxW-1:0];
        w_r = w_rank_wide[IdxW-1:0];
    end

    assign w_ctl.shift  = w_in_acc && !w_drop;
    assign w_ctl.rotate = (r_state == StScan) || (r_state == StDone);

    // cell row: cell 0 takes the new sample on insert; during the scan the
    // window rotates toward the head so every sample passes cell 0 once;
    // cells beyond the window hold their samples
    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
        t_sample   w_prev;
        t_cell_ctl w_cctl;
        if (g == 0) begin : g_head
            assign w_prev = w_ctl.shift ? i_sample_value : w_val[1];
        end else if (g == HISTORY_DEPTH - 1) begin : g_tail
            assign w_prev = w_ctl.shift ? w_val[g-1] : w_val[0];
        end else begin : g_mid
            assign w_prev = w_ctl.shift ? w_val[g-1] : w_val[g+1];
        end
        assign w_cctl.shift  = w_ctl.shift;
        assign w_cctl.rotate = w_ctl.rotate && (IdxW'(g) < r_n);
        swq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_cctl),
            .i_prev        (w_prev),
            .i_wrap        (w_val[0]),
            .i_last_in_win (IdxW'(g) == r_n - 1'b1),
            .o_value       (w_val[g])
        );
    end

    // rank counter: candidate latched from the head at the start of a pass
    swq_rank_cell #(.CntW(IdxW)) u_rank (
        .i_clk   (i_clk),
        .i_load  (r_state == StLoad),
        .i_count (r_state == StScan),
        .i_cand  (w_val[0]),
        .i_probe (w_val[0]),
        .o_cand  (w_cand),
        .o_below (w_below),
        .o_same  (w_same)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_last      <= '0;
            r_win_cfg   <= 8'd75;
            r_rank_cfg  <= 8'd37;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_r         <= '0;
            r_cand      <= '0;
            r_step      <= '0;
            r_found     <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == RegWindowLen) begin
                    r_win_cfg <= i_cfg_data;
                end else begin
                    r_rank_cfg <= i_cfg_data;
                end
            end
            case (r_state)
                StIdle: begin
                    if (w_in_acc && !w_drop) begin
                        if ({1'b0, i_sample_time} > w_lim) begin
                            r_last <= i_sample_time;
                        end else begin
                            r_last <= r_last + StepAdv;
                        end
                        r_n     <= w_n;
                        r_r     <= w_r;
                        r_cand  <= '0;
                        r_found <= 1'b0;
                        r_state <= StLoad;
                    end
                end
                StLoad: begin
                    r_step  <= '0;
                    r_state <= StScan;
                end
                StScan: begin
                    r_step <= r_step + 1'b1;
                    if (w_last_step) begin
                        r_state <= StDone;
                    end
                end
                StDone: begin
                    // window is back in place; w_below/w_same final
                    if (!r_found && w_below <= r_r && r_r < w_below + w_same) begin
                        r_found <= 1'b1;
                        r_hit   <= w_cand;
                    end
                    if (r_cand == r_n - 1'b1) begin
                        r_out_valid <= 1'b1;
                        r_state     <= StIdle;
                    end else begin
                        r_cand  <= r_cand + 1'b1;
                        r_state <= StLoad;
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    // the done state rotates the window one more step, so the next
    // candidate sits at the head; n passes of n+1 steps leave the window
    // in its original order

    // output register; result picked when the last candidate finishes
    always_ff @(posedge i_clk) begin
        if (r_state == StDone && r_cand == r_n - 1'b1) begin
            if (!r_found && w_below <= r_r && r_r < w_below + w_same) begin
                r_out <= w_cand;
            end else if (r_found) begin
                r_out <= r_hit;
            end else begin
                r_out <= w_val[0];
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_quantile_value = r_out;

    `SWQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_quantile_value))
    `SWQ_ASSERT_NOW(a_busy_no_in, i_clk, i_rst_n, r_state != StIdle, !o_ready)
    `SWQ_ASSERT_NOW(a_step_range, i_clk, i_rst_n, r_state == StScan, r_step < r_n)
endmodule
